[src/nis_pkg.sv]
// ----------------------------------------------------------------------------
// nis_pkg
// Shared types, defaults and helpers for the name insertion sorter.
// ----------------------------------------------------------------------------
package nis_pkg;

  localparam int MAX_NAMES_DEF      = 16;
  localparam int WORDS_PER_NAME_DEF = 4;
  localparam int WORD_W             = 64;

  typedef struct packed {
    logic [WORD_W-1:0] name_word;
    logic              word_ends_name;
    logic              name_ends_list;
  } nis_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] sorted_word;
    logic              word_is_final_of_name;
    logic              word_is_final_of_list;
    logic              names_dropped;
  } nis_out_t;

  // controller -> datapath
  typedef struct packed {
    logic take_word;
    logic cp_word;
    logic ins_step;
    logic put_word;
    logic rd_emit;
    logic load_out;
    logic emit_next;
  } nis_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ends_name;
    logic ends_list;
    logic full;
    logic pos_zero;
    logic word_last;
    logic gt;
    logic last_name;
  } nis_sts_t;

  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

[src/nis_stream_if.sv]
// ----------------------------------------------------------------------------
// nis_stream_if
// Valid/ready stream channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface nis_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/nis_ram.sv]
// ----------------------------------------------------------------------------
// nis_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nis_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/nis_dp.sv]
// ----------------------------------------------------------------------------
// nis_dp
// Datapath: pending name, word/name counters, name store and output register.
// ----------------------------------------------------------------------------
module nis_dp import nis_pkg::*; #(
  parameter int MAX_NAMES      = MAX_NAMES_DEF,
  parameter int WORDS_PER_NAME = WORDS_PER_NAME_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  nis_in_t  in_data,
  input  nis_cmd_t cmd,
  output nis_sts_t sts,
  output nis_out_t out_data
);

  localparam int WB = idx_bits(WORDS_PER_NAME);
  localparam int NB = idx_bits(MAX_NAMES);
  localparam int CB = $clog2(MAX_NAMES + 1);
  localparam int AW = NB + WB;

  logic [WORD_W-1:0] pend_r [WORDS_PER_NAME];
  logic [WB-1:0]     wpos_r;
  logic [WB-1:0]     widx_r;
  logic [NB-1:0]     pos_r;
  logic [NB-1:0]     nidx_r;
  logic [CB-1:0]     count_r;
  logic              ovf_r;
  logic              eq_r;
  logic              gt_r;
  nis_out_t          out_r;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] pend_word;
  logic              wpos_last;
  logic              widx_last;
  logic              full;
  logic              last_name;
  logic              ends_name;
  logic [WB-1:0]     widx_inc;

  assign wpos_last = (wpos_r == WB'(WORDS_PER_NAME - 1));
  assign widx_last = (widx_r == WB'(WORDS_PER_NAME - 1));
  assign widx_inc  = widx_last ? '0 : widx_r + WB'(1);
  assign full      = (count_r == CB'(MAX_NAMES));
  assign last_name = (CB'(nidx_r) == count_r - CB'(1));
  assign ends_name = in_data.word_ends_name | wpos_last;
  assign pend_word = pend_r[widx_r];

  assign we    = cmd.cp_word | cmd.put_word;
  assign waddr = {pos_r, widx_r};
  assign wdata = cmd.put_word ? pend_word : rdata;
  assign raddr = cmd.rd_emit ? {nidx_r, widx_r} : {pos_r - NB'(1), widx_r};

  nis_ram #(
    .WIDTH (WORD_W),
    .DEPTH (1 << AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORDS_PER_NAME; i++) begin
        pend_r[i] <= '0;
      end
      wpos_r  <= '0;
      widx_r  <= '0;
      pos_r   <= '0;
      nidx_r  <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      eq_r    <= 1'b1;
      gt_r    <= 1'b0;
    end else begin
      if (cmd.take_word) begin
        if (ends_name && full) begin
          for (int i = 0; i < WORDS_PER_NAME; i++) begin
            pend_r[i] <= '0;
          end
        end else begin
          pend_r[wpos_r] <= in_data.name_word;
        end
        if (ends_name) begin
          wpos_r <= '0;
          pos_r  <= count_r[NB-1:0];
          widx_r <= '0;
          eq_r   <= 1'b1;
          gt_r   <= 1'b0;
          if (full) begin
            ovf_r <= 1'b1;
          end
        end else begin
          wpos_r <= wpos_r + WB'(1);
        end
      end
      if (cmd.cp_word) begin
        widx_r <= widx_inc;
        if (eq_r) begin
          if (rdata > pend_word) begin
            gt_r <= 1'b1;
            eq_r <= 1'b0;
          end else if (rdata != pend_word) begin
            eq_r <= 1'b0;
          end
        end
      end
      if (cmd.ins_step) begin
        pos_r  <= pos_r - NB'(1);
        widx_r <= '0;
        eq_r   <= 1'b1;
        gt_r   <= 1'b0;
      end
      if (cmd.put_word) begin
        widx_r <= widx_inc;
        if (widx_last) begin
          count_r <= count_r + CB'(1);
          for (int i = 0; i < WORDS_PER_NAME; i++) begin
            pend_r[i] <= '0;
          end
        end
      end
      if (cmd.emit_next) begin
        widx_r <= widx_inc;
        if (widx_last) begin
          if (last_name) begin
            nidx_r  <= '0;
            count_r <= '0;
            ovf_r   <= 1'b0;
          end else begin
            nidx_r <= nidx_r + NB'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.sorted_word           <= rdata;
      out_r.word_is_final_of_name <= widx_last;
      out_r.word_is_final_of_list <= widx_last & last_name;
      out_r.names_dropped         <= ovf_r;
    end
  end

  assign out_data = out_r;

  assign sts.ends_name = ends_name;
  assign sts.ends_list = in_data.name_ends_list;
  assign sts.full      = full;
  assign sts.pos_zero  = (pos_r == '0);
  assign sts.word_last = widx_last;
  assign sts.gt        = gt_r;
  assign sts.last_name = last_name;

endmodule

[src/nis_ctrl.sv]
// ----------------------------------------------------------------------------
// nis_ctrl
// Controller: word intake, insertion shift sequence and sorted readout.
// ----------------------------------------------------------------------------
module nis_ctrl import nis_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  nis_sts_t sts,
  output nis_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_RD,
    S_CP,
    S_DEC,
    S_PUT,
    S_ERD,
    S_ELD,
    S_EOUT
  } state_t;

  state_t state_r, state_nxt;
  logic   ends_list_r, ends_list_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    ends_list_nxt = ends_list_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_word = 1'b1;
          if (sts.ends_name) begin
            ends_list_nxt = sts.ends_list;
            if (sts.full) begin
              state_nxt = sts.ends_list ? S_ERD : S_IDLE;
            end else begin
              state_nxt = S_CHK;
            end
          end
        end
      end
      S_CHK: begin
        state_nxt = sts.pos_zero ? S_PUT : S_RD;
      end
      S_RD: begin
        state_nxt = S_CP;
      end
      S_CP: begin
        cmd.cp_word = 1'b1;
        state_nxt   = sts.word_last ? S_DEC : S_RD;
      end
      S_DEC: begin
        if (sts.gt) begin
          cmd.ins_step = 1'b1;
          state_nxt    = S_CHK;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put_word = 1'b1;
        if (sts.word_last) begin
          state_nxt = ends_list_r ? S_ERD : S_IDLE;
        end
      end
      S_ERD: begin
        cmd.rd_emit = 1'b1;
        state_nxt   = S_ELD;
      end
      S_ELD: begin
        cmd.load_out  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_EOUT;
      end
      S_EOUT: begin
        if (out_ready) begin
          cmd.emit_next = 1'b1;
          out_valid_nxt = 1'b0;
          state_nxt     = (sts.word_last && sts.last_name) ? S_IDLE : S_ERD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ends_list_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ends_list_r <= ends_list_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[src/name_insertion_sorter_core.sv]
// ----------------------------------------------------------------------------
// name_insertion_sorter_core
// Insertion sorter for short byte strings sent as 64-bit words.
// ----------------------------------------------------------------------------
// in_s carries one word per beat, first character in the top byte. A name
// ends on word_ends_name or on its WORDS_PER_NAME-th word; name_ends_list on
// that word closes the list. A word that does not end a name leaves in_s ready.
// A name that ends is inserted by a scan down from the top slot that stops at
// slot 0 or at the first stored name not greater than it, and is then written
// into the slot that is left free: each compare reads one stored name a word
// at a time and rewrites it one slot up through the store's port pair.
// A full store drops the name and sets names_dropped for the list.
// After the list closes, out_s sends every stored name in ascending order,
// WORDS_PER_NAME beats each, with a RAM read and a load ahead of each handshake,
// then the block clears its count and flag and takes a new list.
// in_s.ready is low during insertion and readout. A stalled receiver holds
// the current beat in the output register until it is taken.
// Reset (synchronous, active low) empties the store and pending name; it
// needs no clearing pass.
// ----------------------------------------------------------------------------
module name_insertion_sorter_core import nis_pkg::*; #(
  parameter int MAX_NAMES      = MAX_NAMES_DEF,
  parameter int WORDS_PER_NAME = WORDS_PER_NAME_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  nis_stream_if.sink    in_s,
  nis_stream_if.source  out_s
);

  nis_cmd_t cmd;
  nis_sts_t sts;
  nis_in_t  in_data;
  nis_out_t out_data;
  logic     in_ready;
  logic     out_valid;

  assign in_data       = in_s.payload;
  assign in_s.ready    = in_ready;
  assign out_s.valid   = out_valid;
  assign out_s.payload = out_data;

  nis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_s.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nis_dp #(
    .MAX_NAMES      (MAX_NAMES),
    .WORDS_PER_NAME (WORDS_PER_NAME)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

[src/nis_checker.sv]
// ----------------------------------------------------------------------------
// nis_checker
// Port-level checks for the name insertion sorter, bound to the top level.
// ----------------------------------------------------------------------------
module nis_checker import nis_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input nis_out_t out_payload
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out beat withdrawn while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_payload))
    else $error("out beat changed while stalled");

  a_no_intake_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted during readout");

  a_list_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_payload.word_is_final_of_list |=> !out_valid && in_ready)
    else $error("block not idle after final beat of list");

endmodule

bind name_insertion_sorter_core nis_checker u_nis_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_s.ready),
  .out_valid   (out_s.valid),
  .out_ready   (out_s.ready),
  .out_payload (out_s.payload)
);

[tb/nis_sort_checker.sv]
// ----------------------------------------------------------------------------
// nis_sort_checker
// Watches both stream channels of the name insertion sorter, keeps its own
// sorted copy of every list, and checks each readout beat in order: word,
// end-of-name flag, end-of-list flag and the dropped-names flag.
// ----------------------------------------------------------------------------
module nis_sort_checker import nis_pkg::*; #(
  parameter int MAX_NAMES      = MAX_NAMES_DEF,
  parameter int WORDS_PER_NAME = WORDS_PER_NAME_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  nis_in_t  in_beat,
  input  logic     out_valid,
  input  logic     out_ready,
  input  nis_out_t out_beat,
  output int       mismatches,
  output int       results_owed,
  output int       beats_checked,
  output int       lists_closed,
  output int       lists_overflowed
);

  localparam int NAME_W = WORDS_PER_NAME * WORD_W;

  // first word in the top bits, so a plain unsigned compare orders names
  typedef logic [NAME_W-1:0] name_key_t;

  name_key_t sorted_names [MAX_NAMES];
  int        held_names;
  int        word_idx;
  name_key_t partial_name;
  logic      dropped_any;
  nis_out_t  sorted_beats_q [$];

  task automatic clear_list();
    held_names   = 0;
    word_idx     = 0;
    partial_name = '0;
    dropped_any  = 1'b0;
  endtask

  task automatic report_mismatch(string what);
    if (mismatches < 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  task automatic take_word(nis_in_t beat);
    nis_out_t exp_beat;
    int       slot;
    logic     ends;
    partial_name[(WORDS_PER_NAME-1-word_idx)*WORD_W +: WORD_W] = beat.name_word;
    ends = beat.word_ends_name || (word_idx + 1 >= WORDS_PER_NAME);
    if (!ends) begin
      word_idx++;
      return;
    end
    if (held_names >= MAX_NAMES) begin
      dropped_any = 1'b1;
    end else begin
      // equal names stay behind the ones already held
      slot = held_names;
      while (slot > 0 && sorted_names[slot-1] > partial_name) begin
        sorted_names[slot] = sorted_names[slot-1];
        slot--;
      end
      sorted_names[slot] = partial_name;
      held_names++;
    end
    partial_name = '0;
    word_idx     = 0;
    if (!beat.name_ends_list) return;
    lists_closed++;
    if (dropped_any) lists_overflowed++;
    for (int n = 0; n < held_names; n++) begin
      for (int w = 0; w < WORDS_PER_NAME; w++) begin
        exp_beat.sorted_word           = sorted_names[n][(WORDS_PER_NAME-1-w)*WORD_W +: WORD_W];
        exp_beat.word_is_final_of_name = (w == WORDS_PER_NAME - 1);
        exp_beat.word_is_final_of_list = (w == WORDS_PER_NAME - 1) && (n == held_names - 1);
        exp_beat.names_dropped         = dropped_any;
        sorted_beats_q.push_back(exp_beat);
      end
    end
    clear_list();
  endtask

  always @(posedge clk) begin
    nis_out_t exp_beat;
    if (!rst_n) begin
      clear_list();
      sorted_beats_q.delete();
      mismatches       = 0;
      beats_checked    = 0;
      lists_closed     = 0;
      lists_overflowed = 0;
    end else begin
      if (in_valid && in_ready) take_word(in_beat);
      if (out_valid && out_ready) begin
        beats_checked++;
        if (sorted_beats_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, word %h", out_beat.sorted_word));
        end else begin
          exp_beat = sorted_beats_q.pop_front();
          if (out_beat.sorted_word !== exp_beat.sorted_word)
            report_mismatch($sformatf("sorted_word %h, expected %h",
                                      out_beat.sorted_word, exp_beat.sorted_word));
          if (out_beat.word_is_final_of_name !== exp_beat.word_is_final_of_name)
            report_mismatch($sformatf("word_is_final_of_name %b, expected %b",
                                      out_beat.word_is_final_of_name,
                                      exp_beat.word_is_final_of_name));
          if (out_beat.word_is_final_of_list !== exp_beat.word_is_final_of_list)
            report_mismatch($sformatf("word_is_final_of_list %b, expected %b",
                                      out_beat.word_is_final_of_list,
                                      exp_beat.word_is_final_of_list));
          if (out_beat.names_dropped !== exp_beat.names_dropped)
            report_mismatch($sformatf("names_dropped %b, expected %b",
                                      out_beat.names_dropped, exp_beat.names_dropped));
        end
      end
    end
    results_owed = sorted_beats_q.size();
  end

endmodule

[tb/name_insertion_sorter_core_tb.sv]
// ----------------------------------------------------------------------------
// name_insertion_sorter_core_tb
// Feeds lists of names word by word with random gaps on both channels:
// edge values, embedded zero bytes, ties, full-length names, ignored list marks
// and full-store lists, then random lists of text, binary and duplicate names.
// ----------------------------------------------------------------------------
module name_insertion_sorter_core_tb;
  import nis_pkg::*;

  localparam int RANDOM_ITEMS = 340;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 200;
  localparam int POOL_DEPTH   = 32;

  typedef struct {
    logic [3:0][WORD_W-1:0] w;
    int                     nw;
  } name_t;

  logic  clk = 1'b0;
  logic  rst_n;
  bit    steady;
  int    items_sent;
  int    names_sent;
  int    quiet_cycles;
  int    mismatches;
  int    results_owed;
  int    beats_checked;
  int    lists_closed;
  int    lists_overflowed;
  name_t name_pool [POOL_DEPTH];
  int    pool_fill;

  nis_stream_if #(.payload_t(nis_in_t))  in_if ();
  nis_stream_if #(.payload_t(nis_out_t)) out_if ();

  name_insertion_sorter_core DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if.sink),
    .out_s (out_if.source)
  );

  nis_sort_checker sort_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_if.valid),
    .in_ready         (in_if.ready),
    .in_beat          (in_if.payload),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_beat         (out_if.payload),
    .mismatches       (mismatches),
    .results_owed     (results_owed),
    .beats_checked    (beats_checked),
    .lists_closed     (lists_closed),
    .lists_overflowed (lists_overflowed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("no beat for %0d cycles, %0d result beats still owed", quiet_cycles,
               results_owed);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall before each beat
  initial begin
    int hold;
    out_if.ready = 1'b0;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 18);
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  task automatic send_beat(logic [WORD_W-1:0] word, logic ends_name, logic ends_list);
    int      gap;
    nis_in_t beat;
    gap = steady ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.name_word      = word;
    beat.word_ends_name = ends_name;
    beat.name_ends_list = ends_list;
    in_if.valid   <= 1'b1;
    in_if.payload <= beat;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    items_sent++;
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  function automatic name_t make_name();
    name_t nm;
    int    pick;
    int    len;
    nm.w = '0;
    pick = $urandom_range(0, 19);
    if (pick >= 8 && pick < 12 && pool_fill != 0) begin
      // repeat of a recent name, gives ties inside a list
      return name_pool[$urandom_range(0, (pool_fill < POOL_DEPTH ? pool_fill : POOL_DEPTH) - 1)];
    end
    if (pick < 8) begin
      // short alphabet, so prefixes are often shared
      len = $urandom_range(1, 32);
      for (int b = 0; b < len; b++)
        nm.w[b/8][63-8*(b%8) -: 8] = 8'h41 + 8'($urandom_range(0, 3));
      nm.nw = (len + 7) / 8;
      if ($urandom_range(0, 3) == 0) nm.nw = $urandom_range(nm.nw, 4);
    end else if (pick >= 17) begin
      nm.nw = $urandom_range(1, 4);
      for (int b = 0; b < nm.nw * 8; b++)
        nm.w[b/8][63-8*(b%8) -: 8] = ($urandom_range(0, 2) == 0) ? 8'h00
                                                               : 8'($urandom_range(1, 255));
    end else begin
      nm.nw = $urandom_range(1, 4);
      for (int i = 0; i < nm.nw; i++) nm.w[i] = {$urandom, $urandom};
    end
    name_pool[pool_fill % POOL_DEPTH] = nm;
    pool_fill++;
    return nm;
  endfunction

  // a fourth word may leave word_ends_name low; the name ends there anyway
  task automatic send_name(name_t nm, bit closes_list);
    for (int i = 0; i < nm.nw; i++) begin
      if (i == nm.nw - 1)
        send_beat(nm.w[i], (nm.nw < 4) || ($urandom_range(0, 1) == 1), closes_list);
      else
        send_beat(nm.w[i], 1'b0, 1'($urandom_range(0, 1)));
    end
    names_sent++;
  endtask

  initial begin
    int start_items;
    int list_len;
    rst_n         = 1'b0;
    steady        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // one-name list of all ones
    send_beat('1, 1'b1, 1'b1);
    names_sent++;
    // seventeen names: zero, embedded zero byte, a tie, a full-length name with
    // list marks mid-name, then descending one-word names; the last is dropped
    send_beat(64'h0, 1'b1, 1'b0);
    send_beat(64'h4142_0043_0000_0000, 1'b1, 1'b0);
    send_beat(64'h4142_0000_0000_0000, 1'b1, 1'b0);
    send_beat(64'h4142_0000_0000_0000, 1'b1, 1'b0);
    send_beat(64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 1'b1);
    send_beat(64'h0, 1'b0, 1'b1);
    send_beat('1, 1'b0, 1'b0);
    send_beat(64'h8000_0000_0000_0001, 1'b0, 1'b0);
    for (int i = 0; i < 12; i++) send_beat({8'h70 - 8'(i), 56'h0}, 1'b1, i == 11);
    names_sent += 17;
    wait_results_drained();

    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      steady   = ($urandom_range(0, 4) == 0);
      list_len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      for (int n = 0; n < list_len; n++) send_name(make_name(), n == list_len - 1);
      if ($urandom_range(0, 3) == 0) wait_results_drained();
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d words as %0d names in %0d lists, %0d of them over capacity.",
             items_sent, names_sent, lists_closed, lists_overflowed);
    $display("Checked %0d readout beats, %0d mismatches.", beats_checked, mismatches);
    if (mismatches == 0 && results_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
